// ===== hdl/cqrf_pkg.sv =====
// ----------------------------------------------------------------------------
// cqrf_pkg
// Shared types, operation codes and helpers of the command queue with range
// filter.
// ----------------------------------------------------------------------------
package cqrf_pkg;

	localparam int DEPTH_DEF = 16;
	localparam logic [7:0] EMPTY_CODE = 8'd0;

	localparam int OP_W = 3;
	localparam int CMD_W = 8;
	localparam int CNT_OUT_W = 5;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_UNIQUE = 3'd1;
	localparam logic [OP_W-1:0] OP_PURGE = 3'd2;
	localparam logic [OP_W-1:0] OP_POP = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
		logic front;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic out_free;
	} sts_t;

	function automatic logic in_range(input logic [CMD_W-1:0] v,
		input logic [CMD_W-1:0] lo, input logic [CMD_W-1:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

// ===== hdl/cqrf_ram.sv =====
// ----------------------------------------------------------------------------
// cqrf_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cqrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/cqrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqrf_ctrl
// Sequencer of the command queue: accept, slot walk, commit, front read and
// result hand-off.
// ----------------------------------------------------------------------------
module cqrf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cqrf_pkg::sts_t sts,
	output cqrf_pkg::ctl_t ctl
);
	import cqrf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_COMMIT = 3'd2;
	localparam logic [2:0] ST_FRONT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				// last read data is still compared in the cycle that sees walk_done
				if (sts.walk_done) begin
					state_d = ST_COMMIT;
				end else begin
					ctl.step = 1'b1;
				end
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_d = ST_FRONT;
			end
			ST_FRONT: begin
				ctl.front = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/cqrf_dp.sv =====
// ----------------------------------------------------------------------------
// cqrf_dp
// Datapath of the command queue: slot memory, fill count, walk pipeline,
// compaction writer and result register.
// ----------------------------------------------------------------------------
module cqrf_dp #(
	parameter int DEPTH = cqrf_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cqrf_pkg::ctl_t                   ctl,
	output cqrf_pkg::sts_t                   sts,
	input  logic [cqrf_pkg::OP_W-1:0]        op,
	input  logic [cqrf_pkg::CMD_W-1:0]       command,
	input  logic [cqrf_pkg::CMD_W-1:0]       range_low,
	input  logic [cqrf_pkg::CMD_W-1:0]       range_high,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic                             found_in_range,
	output logic                             was_stored,
	output logic [cqrf_pkg::CMD_W-1:0]       front_command,
	output logic [cqrf_pkg::CNT_OUT_W-1:0]   entry_count
);
	import cqrf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [OP_W-1:0]  op_q;
	logic [CMD_W-1:0] cmd_q;
	logic [CMD_W-1:0] lo_q;
	logic [CMD_W-1:0] hi_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          hit_q;
	logic          found_q;
	logic          stored_q;

	logic valid_s1;
	logic first_s1;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CMD_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [CMD_W-1:0] ram_rdata;

	logic not_full;
	logic compact_op;
	logic keep;
	logic walk_hit;
	logic do_store;

	logic             out_valid_q;
	logic             out_found_q;
	logic             out_stored_q;
	logic [CMD_W-1:0] out_front_q;
	logic [CW-1:0]    out_count_q;

	assign not_full = (count_q < FULL_CNT);
	assign compact_op = (op_q == OP_PURGE) || (op_q == OP_POP);

	// pop drops only the first slot, purge drops whatever lies in range
	assign keep = (op_q == OP_PURGE) ? !in_range(ram_rdata, lo_q, hi_q) : !first_s1;

	always_comb begin
		walk_hit = 1'b0;
		if (op_q == OP_UNIQUE) begin
			walk_hit = (ram_rdata == cmd_q);
		end else if (op_q == OP_QUERY) begin
			walk_hit = in_range(ram_rdata, lo_q, hi_q);
		end
	end

	always_comb begin
		do_store = 1'b0;
		if (op_q == OP_APPEND) begin
			do_store = not_full;
		end else if (op_q == OP_UNIQUE) begin
			// an empty command meets the first empty slot as a duplicate
			do_store = not_full && !hit_q && (cmd_q != EMPTY_CODE);
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = wr_q[AW-1:0];
		ram_wdata = ram_rdata;
		if (valid_s1 && compact_op && keep) begin
			ram_we = 1'b1;
		end else if (ctl.commit && do_store) begin
			ram_we = 1'b1;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = cmd_q;
		end
	end

	assign ram_raddr = ctl.front ? '0 : rd_q[AW-1:0];

	cqrf_ram #(
		.WIDTH(CMD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctl.step || ctl.front),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q <= op;
			cmd_q <= command;
			lo_q <= range_low;
			hi_q <= range_high;
		end
		if (ctl.step) begin
			first_s1 <= (rd_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			hit_q <= 1'b0;
			found_q <= 1'b0;
			stored_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.step;
			if (ctl.load) begin
				rd_q <= '0;
				wr_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (ctl.step) begin
					rd_q <= rd_q + 1'b1;
				end
				if (valid_s1) begin
					if (walk_hit) begin
						hit_q <= 1'b1;
					end
					if (compact_op && keep) begin
						wr_q <= wr_q + 1'b1;
					end
				end
			end
			if (ctl.commit) begin
				stored_q <= do_store;
				// empty slots past the fill count take part in the query too
				found_q <= (op_q == OP_QUERY) &&
					(hit_q || (not_full && in_range(EMPTY_CODE, lo_q, hi_q)));
				if (compact_op) begin
					count_q <= wr_q;
				end else if (do_store && (cmd_q != EMPTY_CODE)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign sts.walk_done = (rd_q == count_q);
	assign sts.out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_found_q <= found_q;
			out_stored_q <= stored_q;
			out_front_q <= (count_q == '0) ? EMPTY_CODE : ram_rdata;
			out_count_q <= count_q;
		end
	end

	assign res_valid = out_valid_q;
	assign found_in_range = out_found_q;
	assign was_stored = out_stored_q;
	assign front_command = out_front_q;
	assign entry_count = CNT_OUT_W'(out_count_q);

endmodule

// ===== hdl/command_queue_with_range_filter.sv =====
// ----------------------------------------------------------------------------
// command_queue_with_range_filter
// Packed command queue with append, unique append, range purge, pop and
// range query, one result per request.
// ----------------------------------------------------------------------------
//  channel   dir  tdata bits (lsb first)
//  s_axis    in   op[2:0] command[10:3] range_low[18:11] range_high[26:19]
//  m_axis    out  found_in_range[0] was_stored[1] front_command[9:2]
//                 entry_count[14:10]
//
//  a request runs from acceptance to result through one memory read per
//  stored entry in the slot walk, the last compare, then commit, front read
//  and result load
//  one request at a time; s_axis_tready is high only while the sequencer idles,
//  so the next request can be accepted in the cycle after the result is loaded
//  a held result stalls only the final hand-off, the next request is accepted
//  the fill count makes every slot empty after reset, no clearing pass
// ----------------------------------------------------------------------------
module command_queue_with_range_filter #(
	parameter int DEPTH = cqrf_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], command[10:3], range_low[18:11], range_high[26:19], zero[31:27]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// found_in_range[0], was_stored[1], front_command[9:2], entry_count[14:10],
	// zero[15]
	output logic [15:0] m_axis_tdata
);
	import cqrf_pkg::*;

	ctl_t ctl;
	sts_t sts;

	logic                 found_in_range;
	logic                 was_stored;
	logic [CMD_W-1:0]     front_command;
	logic [CNT_OUT_W-1:0] entry_count;

	cqrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cqrf_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.op            (s_axis_tdata[2:0]),
		.command       (s_axis_tdata[10:3]),
		.range_low     (s_axis_tdata[18:11]),
		.range_high    (s_axis_tdata[26:19]),
		.res_ready     (m_axis_tready),
		.res_valid     (m_axis_tvalid),
		.found_in_range(found_in_range),
		.was_stored    (was_stored),
		.front_command (front_command),
		.entry_count   (entry_count)
	);

	assign m_axis_tdata = {1'b0, entry_count, front_command, was_stored, found_in_range};

endmodule

// ===== hdl/cqrf_checker.sv =====
// ----------------------------------------------------------------------------
// cqrf_checker
// Port level checks of the command queue, bound to the top level.
// ----------------------------------------------------------------------------
module cqrf_checker #(
	parameter int DEPTH = cqrf_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	import cqrf_pkg::*;

	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped before it was taken");

	// one request in flight: acceptance closes the input for the next cycle
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request accepted while one is in flight");

	// only a query finds, only an append or unique append stores
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("found and stored flags both set");

	// an empty queue shows the empty code in front
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		(DEPTH < 32) && m_axis_tvalid && (m_axis_tdata[14:10] == 5'd0)
		|-> (m_axis_tdata[9:2] == EMPTY_CODE))
		else $error("empty queue with a command in front");

	// padding bit stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[15])
		else $error("result padding bit set");

endmodule

bind command_queue_with_range_filter cqrf_checker #(.DEPTH(DEPTH)) u_cqrf_checker (.*);

// ===== bench/command_queue_with_range_filter_test.sv =====
// ----------------------------------------------------------------------------
// command_queue_with_range_filter_test
// Streams append, unique append, purge, pop and query requests into the
// command queue, checking results against a slot-level shadow queue or the
// typed rows of a short table of edge cases that comes first, then bursts
// of random requests biased to fill, drain or mix, with random back-pressure.
// ----------------------------------------------------------------------------
module command_queue_with_range_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cqrf_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int RANDOM_REQUESTS = 1530;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int N_DIRECTED = 23;

	// op codes the block leaves without effect
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CMD_W-1:0] cmd;
		logic [CMD_W-1:0] lo;
		logic [CMD_W-1:0] hi;
	} request_t;

	typedef struct packed {
		logic                 found;
		logic                 stored;
		logic [CMD_W-1:0]     front;
		logic [CNT_OUT_W-1:0] count;
	} status_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		status_t  status;
	} row_t;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// op[2:0], command[10:3], range_low[18:11], range_high[26:19], zero[31:27]
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// found_in_range[0], was_stored[1], front_command[9:2], entry_count[14:10],
	// zero[15]
	logic [15:0] m_axis_tdata;

	logic [CMD_W-1:0] slot_image [DEPTH];
	status_t status_backlog [$];
	int errors = 0;
	int holds_asked = 0;
	int holds_taken = 0;
	bit tx_calm = 0;
	bit rx_calm = 0;
	row_t directed_rows [N_DIRECTED];

	command_queue_with_range_filter #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// shadow queue: apply one request, return what the block should report
	function automatic status_t apply_command(input request_t r);
		status_t s;
		int wr;
		bit done;
		s = '0;
		done = 0;
		wr = 0;
		case (r.op)
			OP_APPEND, OP_UNIQUE: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (!done && r.op == OP_UNIQUE && slot_image[i] == r.cmd)
						done = 1;
					if (!done && slot_image[i] == EMPTY_CODE) begin
						slot_image[i] = r.cmd;
						s.stored = 1'b1;
						done = 1;
					end
				end
			end
			OP_PURGE: begin
				for (int rd = 0; rd < DEPTH; rd++) begin
					if (!(slot_image[rd] >= r.lo && slot_image[rd] <= r.hi)) begin
						slot_image[wr] = slot_image[rd];
						wr++;
					end
				end
				for (int i = wr; i < DEPTH; i++)
					slot_image[i] = EMPTY_CODE;
			end
			OP_POP: begin
				for (int i = 1; i < DEPTH; i++)
					slot_image[i-1] = slot_image[i];
				slot_image[DEPTH-1] = EMPTY_CODE;
			end
			OP_QUERY: begin
				for (int i = 0; i < DEPTH; i++)
					if (slot_image[i] >= r.lo && slot_image[i] <= r.hi)
						s.found = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < DEPTH; i++)
			if (slot_image[i] != EMPTY_CODE)
				s.count = s.count + 1'b1;
		s.front = slot_image[0];
		return s;
	endfunction

	function automatic row_t dir_row(input logic [OP_W-1:0] op,
		input logic [CMD_W-1:0] cmd, input logic [CMD_W-1:0] lo,
		input logic [CMD_W-1:0] hi, input logic typed, input logic found,
		input logic stored, input logic [CMD_W-1:0] front,
		input logic [CNT_OUT_W-1:0] count);
		row_t r;
		r.req = '{op: op, cmd: cmd, lo: lo, hi: hi};
		r.typed = typed;
		r.status = '{found: found, stored: stored, front: front, count: count};
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 93)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CMD_W-1:0] random_cmd();
		case ($urandom_range(0, 2))
			0: return CMD_W'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 3))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd254;
					default: return 8'd255;
				endcase
			end
			default: return CMD_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_range(output logic [CMD_W-1:0] lo, output logic [CMD_W-1:0] hi);
		int top;
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				lo = random_cmd();
				top = lo + $urandom_range(0, 3);
				hi = (top > 255) ? 8'd255 : top[7:0];
			end
			3: begin
				// inverted
				hi = CMD_W'($urandom_range(0, 254));
				lo = CMD_W'($urandom_range(hi + 1, 255));
			end
			4: begin
				lo = CMD_W'($urandom_range(0, 3));
				hi = CMD_W'($urandom_range(200, 255));
			end
			default: begin
				lo = CMD_W'($urandom_range(0, 255));
				hi = CMD_W'($urandom_range(0, 255));
			end
		endcase
	endtask

	function automatic logic [OP_W-1:0] random_op(input burst_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (r < 45) return OP_APPEND;
				if (r < 80) return OP_UNIQUE;
				if (r < 90) return OP_QUERY;
			end
			MODE_DRAIN: begin
				if (r < 40) return OP_POP;
				if (r < 70) return OP_PURGE;
				if (r < 85) return OP_QUERY;
			end
			default: ;
		endcase
		return OP_W'($urandom_range(0, 7));
	endfunction

	// offer one request at the falling edge, hold it until accepted
	task automatic send_request(input request_t r, input logic typed, input status_t typed_status);
		int gap;
		status_t s;
		gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, r.hi, r.lo, r.cmd, r.op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		s = apply_command(r);
		status_backlog.push_back(typed ? typed_status : s);
		@(negedge clk);
	endtask

	// result receiver back-pressure
	initial begin
		int stall_left;
		int rx_cycle;
		stall_left = 0;
		rx_cycle = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (holds_taken != holds_asked) begin
				holds_taken++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
				stall_left = idle_length() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		status_t got;
		status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[9:2], m_axis_tdata[14:10]};
			if (status_backlog.size() == 0) begin
				$error("result with no request outstanding: %h", m_axis_tdata);
				errors++;
			end else begin
				want = status_backlog.pop_front();
				if (got.found !== want.found) begin
					$error("found_in_range: expected %0d, got %0d", want.found, got.found);
					errors++;
				end
				if (got.stored !== want.stored) begin
					$error("was_stored: expected %0d, got %0d", want.stored, got.stored);
					errors++;
				end
				if (got.front !== want.front) begin
					$error("front_command: expected %0d, got %0d", want.front, got.front);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, got.count);
					errors++;
				end
			end
		end
	end

	initial begin
		#15_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		request_t r;
		burst_mode_t mode;
		int issued;
		int burst_left;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		for (int i = 0; i < DEPTH; i++)
			slot_image[i] = EMPTY_CODE;

		directed_rows = '{
			// empty slots count as in range
			dir_row(OP_QUERY, 8'd0, 8'd0, 8'd0, 1, 1, 0, 8'd0, 5'd0),
			dir_row(OP_QUERY, 8'd0, 8'd1, 8'd255, 1, 0, 0, 8'd0, 5'd0),
			dir_row(OP_POP, 8'd0, 8'd0, 8'd0, 1, 0, 0, 8'd0, 5'd0),
			dir_row(OP_RSVD5, 8'd255, 8'd0, 8'd255, 1, 0, 0, 8'd0, 5'd0),
			dir_row(OP_APPEND, 8'd255, 8'd0, 8'd0, 1, 0, 1, 8'd255, 5'd1),
			dir_row(OP_APPEND, EMPTY_CODE, 8'd0, 8'd0, 1, 0, 1, 8'd255, 5'd1),
			dir_row(OP_UNIQUE, EMPTY_CODE, 8'd0, 8'd0, 1, 0, 0, 8'd255, 5'd1),
			dir_row(OP_UNIQUE, 8'd255, 8'd0, 8'd0, 1, 0, 0, 8'd255, 5'd1),
			dir_row(OP_UNIQUE, 8'd1, 8'd0, 8'd0, 1, 0, 1, 8'd255, 5'd2),
			dir_row(OP_APPEND, 8'd1, 8'd0, 8'd0, 1, 0, 1, 8'd255, 5'd3),
			dir_row(OP_QUERY, 8'd0, 8'd255, 8'd1, 1, 0, 0, 8'd255, 5'd3),
			dir_row(OP_APPEND, 8'd128, 8'd0, 8'd0, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_PURGE, 8'd0, 8'd200, 8'd100, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_PURGE, 8'd0, 8'd0, 8'd1, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_QUERY, 8'd0, 8'd255, 8'd255, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_RSVD6, 8'd170, 8'd85, 8'd170, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_RSVD7, 8'd85, 8'd170, 8'd85, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_QUERY, 8'd0, 8'd0, 8'd255, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_PURGE, 8'd0, 8'd255, 8'd255, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_POP, 8'd0, 8'd0, 8'd0, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_POP, 8'd0, 8'd0, 8'd0, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_APPEND, EMPTY_CODE, 8'd0, 8'd0, 0, 0, 0, 8'd0, 5'd0),
			dir_row(OP_PURGE, 8'd0, 8'd0, 8'd255, 0, 0, 0, 8'd0, 5'd0)
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].status);

		issued = 0;
		burst_left = 0;
		mode = MODE_MIX;
		while (issued < RANDOM_REQUESTS) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(30, 60);
				case ($urandom_range(0, 2))
					0: mode = MODE_FILL;
					1: mode = MODE_DRAIN;
					default: mode = MODE_MIX;
				endcase
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			burst_left--;
			if (issued == 300)
				holds_asked++;
			if (issued == 800) begin
				// let every request drain before going on
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
				while (status_backlog.size() != 0)
					@(negedge clk);
			end
			r.op = random_op(mode);
			r.cmd = random_cmd();
			random_range(r.lo, r.hi);
			send_request(r, 1'b0, '0);
			issued++;
		end
		s_axis_tvalid <= 1'b0;

		while (status_backlog.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
